// ----- hw/rtl/crc16_frame_appender_top_defines.svh -----
// Assertion macros for the CRC-16 frame appender.
// Used by RTL modules that carry concurrent checks; no other dependencies.
`ifndef CRC16_FRAME_APPENDER_TOP_DEFINES_SVH
`define CRC16_FRAME_APPENDER_TOP_DEFINES_SVH

`ifndef SYNTH
`define CRCFA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRCFA_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CRCFA_ASSERT(label, clk, rst_n, prop, msg)
`define CRCFA_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// ----- hw/rtl/crcfa_pkg.sv -----
// Shared types and constants for the CRC-16 frame appender.
// No dependencies.
package crcfa_pkg;

    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_end;
        logic       append_crc;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_is_crc;
        logic       out_last;
    } out_item_t;

endpackage

// ----- hw/rtl/crcfa_in_reg.sv -----
// Input register stage: holds one request until the emitter takes it.
// Depends on crcfa_pkg.
module crcfa_in_reg
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  crcfa_pkg::in_item_t src_item,
    output logic                item_valid,
    input  logic                item_take,
    output crcfa_pkg::in_item_t item
);

    logic                valid_reg;
    logic                valid_next;
    crcfa_pkg::in_item_t item_reg;

    // free when empty, or when the held request leaves this cycle
    assign src_stall = valid_reg && !item_take;

    always_comb
    begin
        valid_next = valid_reg;
        if (item_take)
        begin
            valid_next = 1'b0;
        end
        if (src_valid && !src_stall)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_valid && !src_stall)
        begin
            item_reg <= src_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- hw/rtl/crcfa_fold.sv -----
// Folds one byte into a reflected CRC-16, LSB first.
// Depends on crcfa_pkg.
module crcfa_fold
(
    input  logic [15:0] crc_in,
    input  logic [7:0]  data,
    output logic [15:0] crc_out
);

    always_comb
    begin
        logic [15:0] c;
        logic        mix;
        c = crc_in;
        for (int k = 0; k < 8; k++)
        begin
            mix = c[0] ^ data[k];
            c   = {1'b0, c[15:1]} ^ (mix ? crcfa_pkg::CRC_POLY : 16'h0000);
        end
        crc_out = c;
    end

endmodule

// ----- hw/rtl/crcfa_emit.sv -----
// Emitter: running CRC, CRC byte sequencer and the result register.
// Depends on crcfa_pkg, crcfa_fold and the assertion macro header.
`include "crc16_frame_appender_top_defines.svh"

module crcfa_emit
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_take,
    input  crcfa_pkg::in_item_t  item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output crcfa_pkg::out_item_t res_item
);

    typedef enum logic [1:0] {
        EMIT_DATA,
        EMIT_CRC_LO,
        EMIT_CRC_HI
    } emit_state_t;

    emit_state_t          state_reg;
    emit_state_t          state_next;
    logic [15:0]          crc_reg;
    logic [15:0]          crc_next;
    logic [15:0]          pend_crc_reg;
    logic [15:0]          pend_crc_next;
    logic                 res_valid_reg;
    logic                 res_valid_next;
    crcfa_pkg::out_item_t res_item_reg;
    crcfa_pkg::out_item_t res_item_next;
    logic [15:0]          crc_fold;
    logic                 load_out;

    crcfa_fold u_fold
    (
        .crc_in  (crc_reg),
        .data    (item.data_byte),
        .crc_out (crc_fold)
    );

    // result slot frees when empty or being taken downstream
    assign load_out  = !res_valid_reg || !res_stall;
    assign item_take = load_out && (state_reg == EMIT_DATA) && item_valid;

    always_comb
    begin
        state_next     = state_reg;
        crc_next       = crc_reg;
        pend_crc_next  = pend_crc_reg;
        res_valid_next = res_valid_reg;
        res_item_next  = res_item_reg;
        if (load_out)
        begin
            case (state_reg)
                EMIT_CRC_LO:
                begin
                    res_valid_next = 1'b1;
                    res_item_next  = '{out_byte: pend_crc_reg[7:0],
                                       out_is_crc: 1'b1, out_last: 1'b0};
                    state_next     = EMIT_CRC_HI;
                end
                EMIT_CRC_HI:
                begin
                    res_valid_next = 1'b1;
                    res_item_next  = '{out_byte: pend_crc_reg[15:8],
                                       out_is_crc: 1'b1, out_last: 1'b1};
                    state_next     = EMIT_DATA;
                end
                default:
                begin
                    res_valid_next = item_valid;
                    if (item_valid)
                    begin
                        res_item_next = '{out_byte: item.data_byte, out_is_crc: 1'b0,
                                          out_last: item.frame_end && !item.append_crc};
                        if (item.frame_end)
                        begin
                            crc_next = crcfa_pkg::CRC_INIT;
                            if (item.append_crc)
                            begin
                                pend_crc_next = crc_fold;
                                state_next    = EMIT_CRC_LO;
                            end
                        end
                        else
                        begin
                            crc_next = crc_fold;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EMIT_DATA;
            crc_reg       <= crcfa_pkg::CRC_INIT;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            crc_reg       <= crc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_crc_reg <= pend_crc_next;
        res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    `CRCFA_ASSERT(a_pend_holds_result, clk, rst_n, (state_reg != EMIT_DATA) |-> res_valid_reg, "CRC pending with empty result register")
    `CRCFA_ASSERT(a_lo_then_hi, clk, rst_n, (res_valid_reg && res_item_reg.out_is_crc && !res_item_reg.out_last) |-> (state_reg == EMIT_CRC_HI), "CRC low byte shown without high byte pending")
    `CRCFA_ASSERT(a_hi_is_last, clk, rst_n, (load_out && state_reg == EMIT_CRC_HI) |=> (res_item_reg.out_is_crc && res_item_reg.out_last), "CRC high byte not marked last")
    `CRCFA_ASSERT(a_crc_clears, clk, rst_n, (item_take && item.frame_end) |=> (crc_reg == crcfa_pkg::CRC_INIT), "running CRC not cleared after frame")

endmodule

// ----- hw/rtl/crc16_frame_appender_top.sv -----
// Path: a request is held in the input register, then moves to the result register when it is free.
// Throughput: one byte per cycle while res_stall is low; a frame end with CRC append emits
// three bytes, one at a time through the single result register.
// Reset (rst_n low, async): running CRC zero, both stages empty.
// Top level of the CRC-16 frame appender; depends on crcfa_pkg,
// crcfa_in_reg and crcfa_emit.
module crc16_frame_appender_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 src_valid,
    output logic                 src_stall,
    input  crcfa_pkg::in_item_t  src_item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output crcfa_pkg::out_item_t res_item
);

    logic                item_valid;
    logic                item_take;
    crcfa_pkg::in_item_t item;

    crcfa_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_item   (src_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    crcfa_emit u_emit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_item   (res_item)
    );

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for crc16_frame_appender_top: directed and random frames.
// A bit-level CRC-16 predictor is scored against every result; needs crcfa_pkg and the top.
`timescale 1ns / 100ps

module tb;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 src_valid  = 1'b0;
    logic                 src_stall;
    crcfa_pkg::in_item_t  src_item   = '0;
    logic                 res_valid;
    logic                 res_stall  = 1'b0;
    crcfa_pkg::out_item_t res_item;

    // predictor state and pending output bytes
    logic [15:0]          crc_acc = crcfa_pkg::CRC_INIT;
    crcfa_pkg::out_item_t pending_bytes[$];
    int                   mismatches = 0;
    int                   src_idle_pct = 0;
    int                   res_stall_pct = 0;

    crc16_frame_appender_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_item  (src_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(2_000_000);
        $display("tb: FAIL");
        $finish;
    end

    function automatic logic [15:0] crc16_fold(logic [15:0] crc, logic [7:0] b);
        logic mix;
        for (int k = 0; k < 8; k++)
        begin
            mix = b[0] ^ crc[0];
            crc = crc >> 1;
            if (mix)
                crc = crc ^ crcfa_pkg::CRC_POLY;
            b = b >> 1;
        end
        return crc;
    endfunction

    task automatic predict_bytes(crcfa_pkg::in_item_t it);
        logic [15:0]          next_crc;
        crcfa_pkg::out_item_t r;
        next_crc     = crc16_fold(crc_acc, it.data_byte);
        r.out_byte   = it.data_byte;
        r.out_is_crc = 1'b0;
        r.out_last   = it.frame_end && !it.append_crc;
        pending_bytes.push_back(r);
        if (!it.frame_end)
        begin
            crc_acc = next_crc;
        end
        else
        begin
            crc_acc = crcfa_pkg::CRC_INIT;
            if (it.append_crc)
            begin
                r.out_byte   = next_crc[7:0];
                r.out_is_crc = 1'b1;
                r.out_last   = 1'b0;
                pending_bytes.push_back(r);
                r.out_byte   = next_crc[15:8];
                r.out_last   = 1'b1;
                pending_bytes.push_back(r);
            end
        end
    endtask

    // entered and left on a rising edge; returns on the edge that takes the request
    task automatic send_req(logic [7:0] b, logic fend, logic app);
        crcfa_pkg::in_item_t it;
        it.data_byte  = b;
        it.frame_end  = fend;
        it.append_crc = app;
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            src_item  <= crcfa_pkg::in_item_t'(10'($urandom));
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_item  <= it;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        predict_bytes(it);
    endtask

    // receiver back-pressure
    always @(posedge clk)
        res_stall <= ($urandom_range(99) < res_stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte: expected none, got byte %02h crc %b last %b",
                         $time, res_item.out_byte, res_item.out_is_crc, res_item.out_last);
                mismatches++;
            end
            else
            begin
                if (res_item !== pending_bytes[0])
                begin
                    $display({"%0t: mismatch: expected byte %02h crc %b last %b, ",
                              "got byte %02h crc %b last %b"},
                             $time, pending_bytes[0].out_byte, pending_bytes[0].out_is_crc,
                             pending_bytes[0].out_last, res_item.out_byte,
                             res_item.out_is_crc, res_item.out_last);
                    mismatches++;
                end
                void'(pending_bytes.pop_front());
            end
        end
    end

    // standard check string "123456789", CRC 0xBB3D
    task automatic test_check_string();
        byte unsigned s[9] = '{8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39};
        for (int i = 0; i < 9; i++)
            send_req(s[i], i == 8, 1'b1);
    endtask

    task automatic test_single_byte_frames();
        send_req(8'h00, 1'b1, 1'b1);
        send_req(8'hFF, 1'b1, 1'b1);
        send_req(8'hFF, 1'b1, 1'b0);
        send_req(8'h00, 1'b1, 1'b0);
    endtask

    // append flag has no effect until the frame end
    task automatic test_append_mid_frame();
        send_req(8'hA5, 1'b0, 1'b1);
        send_req(8'h5A, 1'b1, 1'b1);
        send_req(8'h3C, 1'b1, 1'b0);
    endtask

    task automatic test_random_frames(int n_reqs);
        int sent = 0;
        int len;
        logic app;
        while (sent < n_reqs)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
            app = ($urandom_range(9) < 7);
            for (int i = 0; i < len; i++)
                send_req(8'($urandom), i == len - 1, (i == len - 1) ? app : 1'($urandom));
            sent += len;
        end
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_check_string();
        test_single_byte_frames();
        test_append_mid_frame();

        src_idle_pct = 0;  res_stall_pct = 0;
        test_random_frames(40);
        src_idle_pct = 79; res_stall_pct = 0;
        test_random_frames(40);
        src_idle_pct = 0;  res_stall_pct = 79;
        test_random_frames(40);
        src_idle_pct = 15; res_stall_pct = 15;
        test_random_frames(40);

        src_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
